### sv/hdbm_pkg.sv
`timescale 1ns / 1ps

package hdbm_pkg;

	localparam int TIME_BITS = 32;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_TAP_MIN     = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CLASS_ONE   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CLASS_TWO   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CLASS_THREE = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FLASH_HALF  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BLINK_CYCLE = 3'd5;

	localparam logic [2:0] CLASS_NONE  = 3'd0;
	localparam logic [2:0] CLASS_ONE   = 3'd1;
	localparam logic [2:0] CLASS_TWO   = 3'd2;
	localparam logic [2:0] CLASS_THREE = 3'd3;
	localparam logic [2:0] CLASS_FOUR  = 3'd4;

	typedef logic [TIME_BITS-1:0] time_t;

	typedef struct packed {
		logic [15:0] tap_min_ms;
		logic [15:0] class_one_max_ms;
		logic [15:0] class_two_max_ms;
		logic [15:0] class_three_max_ms;
		logic [7:0]  flash_half_ms;
		logic [15:0] blink_cycle_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		tap_min_ms:         16'd25,
		class_one_max_ms:   16'd1000,
		class_two_max_ms:   16'd3000,
		class_three_max_ms: 16'd5000,
		flash_half_ms:      8'd60,
		blink_cycle_ms:     16'd1000
	};

endpackage

### sv/hdbm_classify.sv
`timescale 1ns / 1ps

module hdbm_classify (
	input  hdbm_pkg::time_t held,
	input  hdbm_pkg::cfg_t  cfg,
	input  logic [2:0]      cur_class,
	output logic [2:0]      new_class
);

	logic                   neg;
	hdbm_pkg::time_t        tap;
	hdbm_pkg::time_t        c1;
	hdbm_pkg::time_t        c2;
	hdbm_pkg::time_t        c3;

	assign neg = held[hdbm_pkg::TIME_BITS-1];
	assign tap = hdbm_pkg::TIME_BITS'(cfg.tap_min_ms);
	assign c1  = hdbm_pkg::TIME_BITS'(cfg.class_one_max_ms);
	assign c2  = hdbm_pkg::TIME_BITS'(cfg.class_two_max_ms);
	assign c3  = hdbm_pkg::TIME_BITS'(cfg.class_three_max_ms);

	always_comb begin
		new_class = cur_class;
		if (!neg) begin
			if (held > tap && held <= c1) begin
				new_class = hdbm_pkg::CLASS_FOUR;
			end else if (held > c1 && held <= c2) begin
				new_class = hdbm_pkg::CLASS_THREE;
			end else if (held > c2 && held <= c3) begin
				new_class = hdbm_pkg::CLASS_TWO;
			end else if (held > c3) begin
				new_class = hdbm_pkg::CLASS_ONE;
			end
		end
	end

endmodule

### sv/hold_duration_button_menu.sv
`timescale 1ns / 1ps

// Button menu driven by one input beat per millisecond tick carrying the
// button level. A hold is timed and sorted into one of four classes; the
// LED then blinks the class's count (4 down to 1) in flash_half_ms halves,
// grouped into blink_cycle_ms periods. On release after a qualifying hold
// the LED goes off and one result beat carries action_valid and the action
// code. Every input beat yields exactly one result beat. A beat is taken
// every clock cycle: the whole tick update is one pass of logic from the
// state registers into the result register, and the input is ready whenever
// that register is empty or being drained in the same cycle. Configuration
// writes are always ready and take effect on the next beat.
module hold_duration_button_menu (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 button_down,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 led_on,
	output logic                                 action_valid,
	output logic [1:0]                           action,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [hdbm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [hdbm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	hdbm_pkg::cfg_t  cfg_q;

	hdbm_pkg::time_t now_q;
	hdbm_pkg::time_t press_start_q;
	hdbm_pkg::time_t deadline_q;
	logic            led_q;
	logic [7:0]      flash_q;
	logic [2:0]      class_q;
	logic            holding_q;

	logic            out_valid_q;
	logic            led_on_q;
	logic            action_valid_q;
	logic [1:0]      action_q;

	logic            accept;
	logic            press_edge;
	hdbm_pkg::time_t start_eff;
	hdbm_pkg::time_t deadline_eff;
	logic            led_eff;
	logic [7:0]      flash_eff;
	logic [2:0]      class_eff;
	hdbm_pkg::time_t held;
	logic [2:0]      class_new;
	hdbm_pkg::time_t wait_left;
	logic            do_toggle;
	logic            led_tog;
	logic [7:0]      flash_tog;
	logic [11:0]     used;
	hdbm_pkg::time_t next_half;
	hdbm_pkg::time_t next_group;

	hdbm_pkg::time_t press_start_d;
	hdbm_pkg::time_t deadline_d;
	logic            led_d;
	logic [7:0]      flash_d;
	logic [2:0]      class_d;
	logic            holding_d;
	logic            act_valid_d;
	logic [1:0]      act_d;

	assign accept    = in_valid && in_ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	assign press_edge   = button_down && !holding_q;
	assign start_eff    = press_edge ? now_q : press_start_q;
	assign deadline_eff = press_edge ? now_q : deadline_q;
	assign led_eff      = press_edge ? 1'b0 : led_q;
	assign flash_eff    = press_edge ? 8'd0 : flash_q;
	assign class_eff    = press_edge ? hdbm_pkg::CLASS_NONE : class_q;
	assign held         = now_q - start_eff;

	hdbm_classify u_classify (
		.held      (held),
		.cfg       (cfg_q),
		.cur_class (class_eff),
		.new_class (class_new)
	);

	assign wait_left  = deadline_eff - now_q;
	assign do_toggle  = (class_new != hdbm_pkg::CLASS_NONE) &&
		wait_left[hdbm_pkg::TIME_BITS-1];
	assign led_tog    = !led_eff;
	assign flash_tog  = led_tog ? flash_eff : flash_eff + 8'd1;
	// count equals class here, so the product uses the narrow class value
	assign used       = {8'd0, class_new, 1'b0} * {4'd0, cfg_q.flash_half_ms};
	assign next_half  = now_q + hdbm_pkg::TIME_BITS'(cfg_q.flash_half_ms);
	assign next_group = next_half + hdbm_pkg::TIME_BITS'(cfg_q.blink_cycle_ms)
		- hdbm_pkg::TIME_BITS'(used);

	always_comb begin
		press_start_d = press_start_q;
		deadline_d    = deadline_q;
		led_d         = led_q;
		flash_d       = flash_q;
		class_d       = class_q;
		holding_d     = holding_q;
		act_valid_d   = 1'b0;
		act_d         = 2'd0;
		if (button_down) begin
			holding_d     = 1'b1;
			press_start_d = start_eff;
			deadline_d    = deadline_eff;
			led_d         = led_eff;
			flash_d       = flash_eff;
			class_d       = class_new;
			if (do_toggle) begin
				led_d = led_tog;
				if (flash_tog == {5'd0, class_new}) begin
					deadline_d = next_group;
					flash_d    = 8'd0;
				end else begin
					deadline_d = next_half;
					flash_d    = flash_tog;
				end
			end
		end else if (holding_q) begin
			holding_d = 1'b0;
			class_d   = hdbm_pkg::CLASS_NONE;
			if (class_q != hdbm_pkg::CLASS_NONE) begin
				led_d       = 1'b0;
				act_valid_d = 1'b1;
				act_d       = 2'(hdbm_pkg::CLASS_FOUR - class_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= hdbm_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hdbm_pkg::REG_TAP_MIN:     cfg_q.tap_min_ms         <= cfg_data;
				hdbm_pkg::REG_CLASS_ONE:   cfg_q.class_one_max_ms   <= cfg_data;
				hdbm_pkg::REG_CLASS_TWO:   cfg_q.class_two_max_ms   <= cfg_data;
				hdbm_pkg::REG_CLASS_THREE: cfg_q.class_three_max_ms <= cfg_data;
				hdbm_pkg::REG_FLASH_HALF:  cfg_q.flash_half_ms      <= cfg_data[7:0];
				hdbm_pkg::REG_BLINK_CYCLE: cfg_q.blink_cycle_ms     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q         <= '0;
			press_start_q <= '0;
			deadline_q    <= '0;
			led_q         <= 1'b0;
			flash_q       <= 8'd0;
			class_q       <= hdbm_pkg::CLASS_NONE;
			holding_q     <= 1'b0;
		end else if (accept) begin
			now_q         <= now_q + hdbm_pkg::TIME_BITS'(1);
			press_start_q <= press_start_d;
			deadline_q    <= deadline_d;
			led_q         <= led_d;
			flash_q       <= flash_d;
			class_q       <= class_d;
			holding_q     <= holding_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (accept) begin
			led_on_q       <= led_d;
			action_valid_q <= act_valid_d;
			action_q       <= act_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign led_on       = led_on_q;
	assign action_valid = action_valid_q;
	assign action       = action_q;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import hdbm_pkg::*;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

	localparam logic [1:0] ACT_IDLE         = 2'd0;
	localparam logic [1:0] ACT_NEXT_CHANNEL = 2'd0;
	localparam logic [1:0] ACT_NEXT_BAND    = 2'd1;
	localparam logic [1:0] ACT_NEXT_POWER   = 2'd2;
	localparam logic [1:0] ACT_SAVE         = 2'd3;

	typedef enum {PACE_FULL, PACE_RANDOM, PACE_SPARSE} pace_t;

	typedef struct {
		logic       led;
		logic       fired;
		logic [1:0] code;
	} tick_out_t;

	class menu_tick_tracker;
		cfg_t       regs;
		time_t      now_ms;
		time_t      press_ms;
		time_t      toggle_at;
		logic       led;
		logic [7:0] flashes;
		logic [2:0] hold_class;
		logic       holding;
		tick_out_t  expected_ticks[$];
		int         errors;
		int         checked;

		function new();
			regs = CFG_RESET;
			now_ms = '0;
			press_ms = '0;
			toggle_at = '0;
			led = 1'b0;
			flashes = '0;
			hold_class = CLASS_NONE;
			holding = 1'b0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_register(logic [CFG_INDEX_BITS-1:0] idx,
				logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				REG_TAP_MIN:     regs.tap_min_ms = data;
				REG_CLASS_ONE:   regs.class_one_max_ms = data;
				REG_CLASS_TWO:   regs.class_two_max_ms = data;
				REG_CLASS_THREE: regs.class_three_max_ms = data;
				REG_FLASH_HALF:  regs.flash_half_ms = data[7:0];
				REG_BLINK_CYCLE: regs.blink_cycle_ms = data;
				default: ;
			endcase
		endfunction

		function void take_tick(logic down);
			time_t     now;
			time_t     used;
			int        held;
			int        until_toggle;
			tick_out_t r;
			now = now_ms;
			r.fired = 1'b0;
			r.code = ACT_IDLE;
			if (down) begin
				if (!holding) begin
					holding = 1'b1;
					press_ms = now;
					toggle_at = now;
					flashes = '0;
					hold_class = CLASS_NONE;
					led = 1'b0;
				end
				held = $signed(now - press_ms);
				if (held > int'(regs.tap_min_ms) && held <= int'(regs.class_one_max_ms))
					hold_class = CLASS_FOUR;
				else if (held > int'(regs.class_one_max_ms)
						&& held <= int'(regs.class_two_max_ms))
					hold_class = CLASS_THREE;
				else if (held > int'(regs.class_two_max_ms)
						&& held <= int'(regs.class_three_max_ms))
					hold_class = CLASS_TWO;
				else if (held > int'(regs.class_three_max_ms))
					hold_class = CLASS_ONE;
				until_toggle = $signed(toggle_at - now);
				if (hold_class != CLASS_NONE && until_toggle < 0) begin
					led = ~led;
					toggle_at = now + time_t'(regs.flash_half_ms);
					if (!led)
						flashes = flashes + 8'd1;
					if (flashes == 8'(hold_class)) begin
						used = time_t'(flashes) * time_t'(regs.flash_half_ms) * 2;
						toggle_at = toggle_at + time_t'(regs.blink_cycle_ms) - used;
						flashes = '0;
					end
				end
			end else if (holding) begin
				holding = 1'b0;
				if (hold_class != CLASS_NONE) begin
					led = 1'b0;
					r.fired = 1'b1;
					case (hold_class)
						CLASS_FOUR:  r.code = ACT_NEXT_CHANNEL;
						CLASS_THREE: r.code = ACT_NEXT_BAND;
						CLASS_TWO:   r.code = ACT_NEXT_POWER;
						default:     r.code = ACT_SAVE;
					endcase
				end
				hold_class = CLASS_NONE;
			end
			now_ms = now_ms + 1;
			r.led = led;
			expected_ticks.push_back(r);
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task match_tick(logic led_got, logic fired_got, logic [1:0] code_got);
			tick_out_t want;
			if (expected_ticks.size() == 0) begin
				report($sformatf("result beat %0d with nothing expected", checked));
			end else begin
				want = expected_ticks.pop_front();
				if (led_got !== want.led)
					report($sformatf("beat %0d led_on %b, want %b",
						checked, led_got, want.led));
				if (fired_got !== want.fired)
					report($sformatf("beat %0d action_valid %b, want %b",
						checked, fired_got, want.fired));
				if (code_got !== want.code)
					report($sformatf("beat %0d action %0d, want %0d",
						checked, code_got, want.code));
			end
			checked++;
		endtask

		function int pending();
			return expected_ticks.size();
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      button_down = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      led_on;
	logic                      action_valid;
	logic [1:0]                action;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	menu_tick_tracker tracker;
	pace_t            tx_pace = PACE_FULL;
	pace_t            rx_pace = PACE_FULL;

	hold_duration_button_menu uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.button_down  (button_down),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.led_on       (led_on),
		.action_valid (action_valid),
		.action       (action),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int draw_gap(pace_t p);
		case (p)
			PACE_FULL:   return 0;
			PACE_RANDOM: return $urandom_range(0, 17);
			default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
		endcase
	endfunction

	task automatic send_tick(logic level);
		int gap;
		gap = draw_gap(tx_pace);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		button_down <= level;
		do @(posedge clk); while (!in_ready);
		tracker.take_tick(level);
	endtask

	task automatic hold_button(int ticks);
		repeat (ticks) send_tick(1'b1);
	endtask

	task automatic let_go(int ticks);
		repeat (ticks) send_tick(1'b0);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (tracker.pending() > 0) @(posedge clk);
	endtask

	task automatic load_settings(cfg_t s, bit spare);
		logic [CFG_INDEX_BITS-1:0] idx [8];
		logic [CFG_DATA_BITS-1:0]  dat [8];
		int                        n;
		idx[0] = REG_TAP_MIN;     dat[0] = s.tap_min_ms;
		idx[1] = REG_CLASS_ONE;   dat[1] = s.class_one_max_ms;
		idx[2] = REG_CLASS_TWO;   dat[2] = s.class_two_max_ms;
		idx[3] = REG_CLASS_THREE; dat[3] = s.class_three_max_ms;
		idx[4] = REG_FLASH_HALF;  dat[4] = {8'($urandom_range(0, 255)), s.flash_half_ms};
		idx[5] = REG_BLINK_CYCLE; dat[5] = s.blink_cycle_ms;
		n = 6;
		if (spare) begin
			idx[6] = REG_SPARE_LO; dat[6] = 16'($urandom);
			idx[7] = REG_SPARE_HI; dat[7] = 16'($urandom);
			n = 8;
		end
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= dat[i];
			do @(posedge clk); while (!cfg_ready);
			tracker.set_register(idx[i], dat[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic cfg_t random_settings();
		cfg_t s;
		s.tap_min_ms = 16'($urandom_range(0, 6));
		if ($urandom_range(0, 3) == 0) begin
			// unordered thresholds
			s.class_one_max_ms = 16'($urandom_range(0, 40));
			s.class_two_max_ms = 16'($urandom_range(0, 40));
			s.class_three_max_ms = 16'($urandom_range(0, 40));
		end else begin
			s.class_one_max_ms = s.tap_min_ms + 16'($urandom_range(0, 12));
			s.class_two_max_ms = s.class_one_max_ms + 16'($urandom_range(0, 12));
			s.class_three_max_ms = s.class_two_max_ms + 16'($urandom_range(0, 12));
		end
		s.flash_half_ms = 8'($urandom_range(1, 5));
		s.blink_cycle_ms = 16'($urandom_range(0, 60));
		return s;
	endfunction

	task automatic random_holds(int items, int cap);
		int count;
		int len;
		int th;
		int pick;
		int n;
		count = 0;
		while (count < items) begin
			pick = $urandom_range(0, 9);
			if (pick < 8) begin
				len = $urandom_range(1, cap);
				if (pick < 4) begin
					// land right on a class boundary
					case ($urandom_range(0, 3))
						0:       th = int'(tracker.regs.tap_min_ms);
						1:       th = int'(tracker.regs.class_one_max_ms);
						2:       th = int'(tracker.regs.class_two_max_ms);
						default: th = int'(tracker.regs.class_three_max_ms);
					endcase
					if (th + 3 <= cap)
						len = th + $urandom_range(0, 3);
				end
				if (len < 1)
					len = 1;
				n = $urandom_range(1, 4);
				hold_button(len);
				let_go(n);
				count += len + n;
			end else begin
				n = $urandom_range(1, 5);
				repeat (n) send_tick(1'($urandom_range(0, 1)));
				count += n;
			end
		end
	endtask

	task automatic run_phase(cfg_t s, pace_t p, int items, int cap, bit spare);
		drain_results();
		load_settings(s, spare);
		tx_pace = p;
		random_holds(items, cap);
	endtask

	initial begin
		cfg_t s;
		int   cap;
		tracker = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: release while idle, short tap
		tx_pace = PACE_SPARSE;
		let_go(1);
		hold_button(1);
		let_go(1);

		// one hold per class on tight thresholds
		drain_results();
		load_settings('{tap_min_ms: 16'd0, class_one_max_ms: 16'd1, class_two_max_ms: 16'd2,
			class_three_max_ms: 16'd3, flash_half_ms: 8'd1, blink_cycle_ms: 16'd5}, 1'b0);
		hold_button(1);
		let_go(1);
		hold_button(2);
		let_go(1);
		hold_button(3);
		let_go(1);
		hold_button(4);
		let_go(1);
		hold_button(6);
		let_go(1);

		// class drops below the flash count mid-group
		drain_results();
		load_settings('{tap_min_ms: 16'd0, class_one_max_ms: 16'd12, class_two_max_ms: 16'd12,
			class_three_max_ms: 16'd2000, flash_half_ms: 8'd1, blink_cycle_ms: 16'd30}, 1'b0);
		tx_pace = PACE_FULL;
		hold_button(60);
		let_go(2);

		run_phase(CFG_RESET, PACE_SPARSE, 100, 40, 1'b0);
		run_phase('{tap_min_ms: 16'd0, class_one_max_ms: 16'hffff,
			class_two_max_ms: 16'hffff, class_three_max_ms: 16'hffff,
			flash_half_ms: 8'd255, blink_cycle_ms: 16'hffff}, PACE_RANDOM, 60, 60, 1'b0);
		run_phase('{tap_min_ms: 16'hffff, class_one_max_ms: 16'd0,
			class_two_max_ms: 16'd0, class_three_max_ms: 16'd0,
			flash_half_ms: 8'd1, blink_cycle_ms: 16'd0}, PACE_FULL, 60, 30, 1'b1);
		for (int k = 0; k < 8; k++) begin
			s = random_settings();
			cap = int'(s.class_one_max_ms);
			if (int'(s.class_two_max_ms) > cap)
				cap = int'(s.class_two_max_ms);
			if (int'(s.class_three_max_ms) > cap)
				cap = int'(s.class_three_max_ms);
			cap = cap + 10;
			if (cap > 90)
				cap = 90;
			run_phase(s, pace_t'(k % 3), 60, cap, k == 3);
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// long hold-off so the block backs up into its input
			if (tracker.checked == 300)
				stall = 60;
			else
				stall = draw_gap(rx_pace);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			tracker.match_tick(led_on, action_valid, action);
			if (tracker.checked % 64 == 0)
				rx_pace = pace_t'($urandom_range(0, 2));
		end
	end

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
